### hdl/jse_pkg.sv
// shared types, character constants and helpers for the json string escaper
// no dependencies; imported by every module of the block
package jse_pkg;

  localparam int CAP_BITS          = 16;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 16'hFFFF;
  localparam int COUNT_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int PIECE_MAX         = 6;
  localparam int IDX_BITS          = $clog2(PIECE_MAX);

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_LOW   = 8'h61;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_mark;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       status;
    logic       last;
  } out_word_t;

  // what the back end has to emit for one queued entry
  typedef enum logic [2:0] {
    CMD_PASS,
    CMD_ESC2,
    CMD_UNI,
    CMD_OVF,
    CMD_TERM
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t  code;
    logic [7:0] data;
    logic       status;
  } cmd_t;

  function automatic logic [IDX_BITS-1:0] cmd_len_m1(cmd_code_t code);
    logic [IDX_BITS-1:0] r;
    case (code)
      CMD_ESC2: r = IDX_BITS'(1);
      CMD_UNI:  r = IDX_BITS'(PIECE_MAX - 1);
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_A_LOW + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

### hdl/jse_front.sv
// front end: accepts items, classifies each byte, keeps the running count
// and overflow flag, and queues one command per result group
// depends on jse_pkg
module jse_front #(
  parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  jse_pkg::in_word_t              item,
  input  logic                           accept,
  input  logic                           cfg_write,
  input  logic [jse_pkg::CAP_BITS-1:0]   cfg_data,
  output logic                           push,
  output jse_pkg::cmd_t                  push_cmd
);
  import jse_pkg::*;

  localparam int CMP_W = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 2;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'({COUNT_BITS{1'b1}});

  logic [CAP_BITS-1:0]   output_capacity;
  logic [COUNT_BITS-1:0] bytes_used;
  logic                  overflowed;

  cmd_code_t             code;
  logic [7:0]            data;
  logic [CMP_W-1:0]      sum;
  logic [CMP_W-1:0]      cap_ext;
  logic                  fits;
  logic                  term_bad;

  // classify the byte
  always_comb begin
    data = item.char_byte;
    if (item.char_byte == CH_QUOTE || item.char_byte == CH_BSLASH) begin
      code = CMD_ESC2;
    end else if (item.char_byte == CH_LF) begin
      code = CMD_ESC2;
      data = CH_N;
    end else if (item.char_byte == CH_CR) begin
      code = CMD_ESC2;
      data = CH_R;
    end else if (item.char_byte == CH_TAB) begin
      code = CMD_ESC2;
      data = CH_T;
    end else if (item.char_byte < CTRL_LIMIT) begin
      code = CMD_UNI;
    end else begin
      code = CMD_PASS;
    end
  end

  // capacity check, one place kept for the terminator
  always_comb begin
    cap_ext  = CMP_W'(output_capacity);
    sum      = CMP_W'(bytes_used) + CMP_W'(cmd_len_m1(code)) + CMP_W'(1);
    fits     = (sum <= COUNT_MAX) && (sum + CMP_W'(1) <= cap_ext);
    term_bad = (CMP_W'(bytes_used) + CMP_W'(1)) > cap_ext;
  end

  always_comb begin
    push     = 1'b0;
    push_cmd = '{code: code, data: data, status: 1'b0};
    if (accept) begin
      if (item.end_mark) begin
        push     = !overflowed;
        push_cmd = '{code: CMD_TERM, data: 8'd0, status: term_bad};
      end else if (!overflowed) begin
        push = 1'b1;
        if (!fits) begin
          push_cmd = '{code: CMD_OVF, data: 8'd0, status: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_capacity <= CAP_RESET;
      bytes_used      <= '0;
      overflowed      <= 1'b0;
    end else begin
      if (cfg_write) begin
        output_capacity <= cfg_data;
      end
      if (accept && item_valid) begin
        if (item.end_mark) begin
          bytes_used <= '0;
          overflowed <= 1'b0;
        end else if (!overflowed) begin
          if (fits) begin
            bytes_used <= sum[COUNT_BITS-1:0];
          end else begin
            overflowed <= 1'b1;
          end
        end
      end
    end
  end

endmodule

### hdl/jse_fifo.sv
// short command queue between the front and back ends
// depends on jse_pkg
module jse_fifo #(
  parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jse_pkg::cmd_t push_cmd,
  input  logic          pop,
  output jse_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import jse_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/jse_back.sv
// back end: expands each queued command into output words, one per cycle
// while result_stall is low, through a registered output stage
// depends on jse_pkg
module jse_back (
  input  logic               clk,
  input  logic               rst,
  input  jse_pkg::cmd_t      head,
  input  logic               empty,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output jse_pkg::out_word_t result
);
  import jse_pkg::*;

  logic [IDX_BITS-1:0] idx;
  logic                load;
  logic                at_end;
  out_word_t           gen;

  assign load   = !result_valid || !result_stall;
  assign at_end = (idx == cmd_len_m1(head.code));
  assign pop    = load && !empty && at_end;

  always_comb begin
    gen = '{out_byte: head.data, status: 1'b0, last: 1'b0};
    case (head.code)
      CMD_PASS: gen.out_byte = head.data;
      CMD_ESC2: gen.out_byte = (idx == '0) ? CH_BSLASH : head.data;
      CMD_UNI: begin
        case (idx)
          IDX_BITS'(0): gen.out_byte = CH_BSLASH;
          IDX_BITS'(1): gen.out_byte = CH_U;
          IDX_BITS'(2): gen.out_byte = CH_ZERO;
          IDX_BITS'(3): gen.out_byte = CH_ZERO;
          IDX_BITS'(4): gen.out_byte = hex_char(head.data[7:4]);
          default:      gen.out_byte = hex_char(head.data[3:0]);
        endcase
      end
      CMD_OVF:  gen = '{out_byte: 8'd0, status: 1'b1, last: 1'b1};
      CMD_TERM: gen = '{out_byte: 8'd0, status: head.status, last: 1'b1};
      default:  gen = '{out_byte: 8'd0, status: 1'b0, last: 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      result <= gen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= !empty;
      if (!empty) begin
        idx <= at_end ? '0 : idx + IDX_BITS'(1);
      end
    end
  end

endmodule

### hdl/json_string_escaper.sv
// top level of the json string escaper: front end, command queue, back end
// depends on jse_pkg, jse_front, jse_fifo, jse_back
//
// usage
//   item channel: item_valid / item_stall carry one word per item, either a
//   string byte (end_mark 0) or the end of the string (end_mark 1)
//   result channel: result_valid / result_stall carry one escaped byte per
//   word; last marks the terminator or the single overflow word
//   cfg channel: cfg_valid / cfg_ready write output_capacity; cfg_ready is
//   always high, write only while the block is idle
// path: an item's first word is queued, then loaded into the output register
// throughput: one result word per cycle while result_stall is low, set by
//   the back end's single output register; a plain byte gives 1 word, an
//   escape pair 2, a \u00xx form 6, and the command queue absorbs the
//   expansion until it fills, when item_stall rises
// reset: the count and overflow flag clear, capacity returns to 65535, the
//   queue empties and result_valid drops
// stall: while result_stall is high the output word holds; the queue keeps
//   taking items until full, then item_stall holds off the sender
module json_string_escaper #(
  parameter int COUNT_BITS  = jse_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  jse_pkg::in_word_t            item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output jse_pkg::out_word_t           result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [jse_pkg::CAP_BITS-1:0] cfg_data
);
  import jse_pkg::*;

  logic accept;
  logic push;
  cmd_t push_cmd;
  cmd_t head;
  logic empty;
  logic full;
  logic pop;

  // the queue being full is the only thing that holds off the sender
  assign item_stall = full;
  assign accept     = item_valid && !full;
  assign cfg_ready  = 1'b1;

  jse_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .accept    (accept),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // decouples classification from the multi-cycle expansion
  jse_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  jse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

### sim/testbench.sv
// self-checking testbench for the json string escaper: directed strings, then random ones
// depends on jse_pkg and json_string_escaper from the hdl folder
`timescale 1ns / 100ps

module testbench;
  import jse_pkg::*;

  localparam int CYCLE_LIMIT   = 60000;
  localparam int SETTLE_CYCLES = 16;   // extra wait once no word is owed, past the queue and output register
  localparam int LONG_HOLD     = 60;   // receiver hold-off used to back up the queue
  localparam int RANDOM_ITEMS  = 60;
  localparam int COUNT_LIMIT   = (1 << COUNT_BITS_DEF) - 1;

  // opening string: every escape class plus the extremes of the byte field
  localparam logic [7:0] OPENING [11] = '{CH_QUOTE, CH_BSLASH, CH_LF, CH_CR, CH_TAB,
                                          8'h00, 8'h1f, 8'h20, 8'hff, 8'h80, 8'h7f};

  // escaping predictor plus the queue of result words still owed by the block
  class escape_scoreboard;
    int        capacity;
    int        used;
    bit        failed;
    string     hex_digits;
    out_word_t awaited_bytes[$];
    int        errors;
    int        words_checked;
    int        overflow_words;

    function new();
      capacity   = int'(CAP_RESET);
      used       = 0;
      failed     = 1'b0;
      hex_digits = "0123456789abcdef";
    endfunction

    function void queue_word(logic [7:0] b, logic st, logic lst);
      out_word_t w;
      w.out_byte = b;
      w.status   = st;
      w.last     = lst;
      awaited_bytes.push_back(w);
    endfunction

    // note an accepted input word; returns 1 when the block simply drops it
    function bit take_char(in_word_t w);
      logic [7:0] piece [6];
      int         len;
      logic [7:0] c;
      c = w.char_byte;
      if (w.end_mark) begin
        // terminator only if the string has not already overflowed
        if (!failed) queue_word(8'h00, (used + 1 > capacity), 1'b1);
        used   = 0;
        failed = 1'b0;
        return 1'b0;
      end
      if (failed) return 1'b1;
      len      = 2;
      piece[0] = CH_BSLASH;
      if (c == CH_QUOTE || c == CH_BSLASH) piece[1] = c;
      else if (c == CH_LF) piece[1] = CH_N;
      else if (c == CH_CR) piece[1] = CH_R;
      else if (c == CH_TAB) piece[1] = CH_T;
      else if (c < CTRL_LIMIT) begin
        len      = 6;
        piece[1] = CH_U;
        piece[2] = CH_ZERO;
        piece[3] = CH_ZERO;
        piece[4] = hex_digits[c[7:4]];
        piece[5] = hex_digits[c[3:0]];
      end else begin
        len      = 1;
        piece[0] = c;
      end
      // one place always stays free for the terminator
      if (used + len + 1 > capacity || used + len > COUNT_LIMIT) begin
        failed = 1'b1;
        queue_word(8'h00, 1'b1, 1'b1);
        return 1'b0;
      end
      for (int k = 0; k < len; k++) queue_word(piece[k], 1'b0, 1'b0);
      used = used + len;
      return 1'b0;
    endfunction

    function void check_byte(out_word_t got);
      out_word_t want;
      words_checked++;
      if (got.status) overflow_words++;
      if (awaited_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got byte %02h status %0d last %0d",
                 $time, got.out_byte, got.status, got.last);
        return;
      end
      want = awaited_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.status !== want.status ||
          got.last !== want.last) begin
        errors++;
        $display("%0t: word mismatch, expected byte %02h status %0d last %0d, got byte %02h status %0d last %0d",
                 $time, want.out_byte, want.status, want.last,
                 got.out_byte, got.status, got.last);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  in_word_t            item;
  logic                result_valid;
  logic                result_stall;
  out_word_t           result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CAP_BITS-1:0] cfg_data;

  escape_scoreboard board = new();

  bit calm;          // no random idling on either side while set; a requested long hold still applies
  bit hold_request;  // receiver holds off with the LONG_HOLD gap after its next word
  int live_items;    // items the block acts on, ignored bytes left out
  int settings;      // capacity writes done
  int cycle_count;
  int backpressure_cycles;

  json_string_escaper i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, also counts cycles in which the block held off the sender
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && item_valid && item_stall) backpressure_cycles <= backpressure_cycles + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, board.awaited_bytes.size());
      $display("FAIL json_string_escaper");
      $finish;
    end
  end

  // receiver: checks every accepted word, then draws a random stall gap;
  // a requested long hold is counted here so the sender keeps offering meanwhile
  initial begin : result_sink
    int gap;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        board.check_byte(result);
        gap = calm ? 0 : $urandom_range(0, 3);
        if (hold_request) begin
          hold_request = 1'b0;
          gap = LONG_HOLD;
        end
        if (gap > 0) begin
          @(negedge clk);
          result_stall <= 1'b1;
          repeat (gap) @(negedge clk);
          result_stall <= 1'b0;
        end
      end
    end
  end

  // offer one word after a random gap, hold it until taken, then note it
  task automatic send_item(input logic [7:0] c, input logic end_flag);
    in_word_t w;
    int       gap;
    w.char_byte = c;
    w.end_mark  = end_flag;
    gap = calm ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (item_stall);
    if (!board.take_char(w)) live_items++;
  endtask

  // sender pauses until every owed word is in, then lets the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (board.awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.capacity = int'(v);
    settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly printable text, with a heavy share of escapes and control bytes
  function automatic logic [7:0] pick_char();
    logic [7:0] specials [5];
    specials = '{CH_QUOTE, CH_BSLASH, CH_LF, CH_CR, CH_TAB};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(32, 126));
      4:          return specials[$urandom_range(0, 4)];
      5, 6:       return 8'($urandom_range(0, 31));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_string(input int len);
    for (int i = 0; i < len; i++) send_item(pick_char(), 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);  // byte field is don't-care on the end word
  endtask

  initial begin : stimulus
    int random_goal;
    int phase;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    live_items   = 0;
    settings     = 0;
    cycle_count  = 0;
    backpressure_cycles = 0;
    phase        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset capacity: every escape class and both byte extremes, nothing overflows
    foreach (OPENING[i]) send_item(OPENING[i], 1'b0);
    send_item(8'ha5, 1'b1);
    wait_idle();

    // zero capacity: even the terminator has no room, then a byte overflows
    // and the rest of that string is dropped, end word included
    write_capacity(16'd0);
    send_item(8'h5a, 1'b1);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h00, 1'b1);
    wait_idle();

    // exact fit: two bytes plus the terminator fill a 3-byte buffer
    write_capacity(16'd3);
    send_item(8'h78, 1'b0);
    send_item(8'h79, 1'b0);
    send_item(8'h00, 1'b1);
    wait_idle();

    // capacity lowered between words of one string, down to what is already used
    write_capacity(16'hffff);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    wait_idle();
    write_capacity(16'd2);
    send_item(8'h3c, 1'b1);
    // an escape pair that no longer fits after one plain byte
    send_item(8'h63, 1'b0);
    send_item(CH_LF, 1'b0);
    send_item(8'h64, 1'b0);
    send_item(8'h00, 1'b1);
    wait_idle();

    // random phases: a capacity setting, a few strings, then drain before the next write
    random_goal = live_items + RANDOM_ITEMS;
    while (live_items < random_goal) begin
      phase++;
      calm = (phase % 4 == 3);
      case ($urandom_range(0, 6))
        0:       write_capacity(16'd1);
        1:       write_capacity(CAP_BITS'($urandom_range(2, 12)));
        2, 3:    write_capacity(CAP_BITS'($urandom_range(13, 60)));
        4:       write_capacity(16'hffff);
        default: write_capacity(CAP_BITS'($urandom_range(0, 65535)));
      endcase
      if (phase == 2) begin
        // receiver holds off while a run of control bytes floods the queue
        write_capacity(16'hffff);
        calm         = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++) send_item(8'($urandom_range(0, 31)), 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        calm = 1'b0;
      end
      repeat ($urandom_range(2, 4)) send_string($urandom_range(0, 12));
      wait_idle();
    end

    $display("covered %0d live items over %0d capacity settings, %0d words checked",
             live_items, settings, board.words_checked);
    $display("%0d overflow words, %0d cycles of input back-pressure",
             board.overflow_words, backpressure_cycles);
    if (board.errors == 0 && board.awaited_bytes.size() == 0) begin
      $display("PASS json_string_escaper");
    end else begin
      $display("FAIL json_string_escaper");
    end
    $finish;
  end

endmodule
